// ===== sv/sld_pkg.sv =====
`default_nettype none

package sld_pkg;

    localparam logic [7:0] SYNC_FIRST   = 8'hA5;
    localparam logic [7:0] SYNC_SECOND  = 8'h5A;
    localparam logic [7:0] CLASS_SCALE  = 8'h01;
    localparam logic [7:0] TYPE_WEIGHT  = 8'h01;
    localparam logic [7:0] TYPE_BATTERY = 8'h05;
    localparam int         FRAME_OVERHEAD = 8;
    localparam int         TRAILER_BYTES  = FRAME_OVERHEAD - 6;

    localparam logic       CMD_DATA = 1'b0;
    localparam logic       CMD_DROP = 1'b1;

    typedef enum logic [1:0] {
        KIND_WEIGHT  = 2'd0,
        KIND_BATTERY = 2'd1,
        KIND_OTHER   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_CLASS = 3'd2,
        PH_TYPE  = 3'd3,
        PH_LENHI = 3'd4,
        PH_LENLO = 3'd5,
        PH_BODY  = 3'd6
    } phase_t;

    typedef struct packed {
        logic       command;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         frame_kind;
        logic [7:0]         class_code;
        logic [7:0]         type_code;
        logic [15:0]        payload_length;
        logic signed [31:0] weight_tenths;
        logic [7:0]         battery_level;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/sld_in_if.sv =====
`default_nettype none

interface sld_in_if;
    logic               valid;
    logic               ready;
    sld_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/sld_out_if.sv =====
`default_nettype none

interface sld_out_if;
    logic               valid;
    logic               ready;
    sld_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/sync_length_frame_decoder.sv =====
// Frame decoder for a byte stream carrying A5 5A sync, class, type, a 16-bit
// big-endian length, the payload and two unchecked trailer bytes.
// Channel bytes takes one item per received byte (command 0) or a link-drop
// command (command 1) that discards any partial frame and emits nothing.
// Channel frames gives one item per complete frame, when its last trailer
// byte has been taken: kind, class, type, length, the weight in tenths of a
// gram and the battery level.
// An input item is accepted whenever bytes.ready is high, so a new one can be
// taken in every cycle while the skid register is empty. A finished frame item
// is registered in the output register, or in the skid one if that is full and not read.
// The output register is backed by one skid register, so input keeps flowing
// while a finished item waits. Only when both are full does bytes.ready fall,
// and it rises again in the cycle after the receiver takes an item.
// Reset returns the parser to hunting for the first sync byte and empties the
// output register and the skid register.
`default_nettype none

module sync_length_frame_decoder (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sld_in_if.sink     bytes,
    sld_out_if.source  frames
);

    sld_pkg::phase_t    phase_reg, phase_next;
    logic [7:0]         class_reg, class_next;
    logic [7:0]         type_reg, type_next;
    logic [15:0]        length_reg, length_next;
    logic [16:0]        left_reg, left_next;
    logic [31:0]        word_reg, word_next;

    sld_pkg::out_item_t out_data_reg, skid_data_reg;
    logic               out_valid_reg, skid_valid_reg;

    logic               accept;
    logic               pop;
    logic               done;
    logic [16:0]        total;
    logic [16:0]        pos;
    logic [7:0]         b;
    sld_pkg::out_item_t result;

    assign bytes.ready  = !skid_valid_reg;
    assign accept       = bytes.valid && bytes.ready;
    assign pop          = out_valid_reg && frames.ready;
    assign frames.valid = out_valid_reg;
    assign frames.data  = out_data_reg;

    assign b     = bytes.data.byte_value;
    assign total = {1'b0, length_reg} + 17'(sld_pkg::TRAILER_BYTES);
    assign pos   = total - left_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        class_next  = class_reg;
        type_next   = type_reg;
        length_next = length_reg;
        left_next   = left_reg;
        word_next   = word_reg;
        done        = 1'b0;
        if (bytes.data.command == sld_pkg::CMD_DROP) begin
            phase_next  = sld_pkg::PH_HUNT;
            class_next  = '0;
            type_next   = '0;
            length_next = '0;
            left_next   = '0;
            word_next   = '0;
        end else begin
            case (phase_reg)
                sld_pkg::PH_HUNT:
                begin
                    if (b == sld_pkg::SYNC_FIRST) begin
                        phase_next = sld_pkg::PH_SYNC2;
                    end
                end
                sld_pkg::PH_SYNC2:
                begin
                    if (b == sld_pkg::SYNC_SECOND) begin
                        phase_next = sld_pkg::PH_CLASS;
                        word_next  = '0;
                    end else if (b != sld_pkg::SYNC_FIRST) begin
                        phase_next = sld_pkg::PH_HUNT;
                    end
                end
                sld_pkg::PH_CLASS:
                begin
                    class_next = b;
                    phase_next = sld_pkg::PH_TYPE;
                end
                sld_pkg::PH_TYPE:
                begin
                    type_next  = b;
                    phase_next = sld_pkg::PH_LENHI;
                end
                sld_pkg::PH_LENHI:
                begin
                    length_next = {b, 8'h00};
                    phase_next  = sld_pkg::PH_LENLO;
                end
                sld_pkg::PH_LENLO:
                begin
                    length_next = {length_reg[15:8], b};
                    left_next   = {1'b0, length_reg[15:8], b}
                                  + 17'(sld_pkg::TRAILER_BYTES);
                    phase_next  = sld_pkg::PH_BODY;
                end
                sld_pkg::PH_BODY:
                begin
                    if (pos < 17'd4 && pos < {1'b0, length_reg}) begin
                        case (pos[1:0])
                            2'd0:    word_next[31:24] = word_reg[31:24] | b;
                            2'd1:    word_next[23:16] = word_reg[23:16] | b;
                            2'd2:    word_next[15:8]  = word_reg[15:8] | b;
                            default: word_next[7:0]   = word_reg[7:0] | b;
                        endcase
                    end
                    left_next = left_reg - 17'd1;
                    if (left_reg == 17'd1) begin
                        done       = 1'b1;
                        phase_next = sld_pkg::PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = sld_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // The last body byte is always a trailer byte, so the payload word is
    // already complete in word_reg when the frame ends.
    always_comb
    begin
        result.frame_kind     = sld_pkg::KIND_OTHER;
        result.class_code     = class_reg;
        result.type_code      = type_reg;
        result.payload_length = length_reg;
        result.weight_tenths  = '0;
        result.battery_level  = '0;
        if (class_reg == sld_pkg::CLASS_SCALE && type_reg == sld_pkg::TYPE_WEIGHT
            && length_reg >= 16'd4) begin
            result.frame_kind    = sld_pkg::KIND_WEIGHT;
            result.weight_tenths = word_reg;
        end else if (class_reg == sld_pkg::CLASS_SCALE
                     && type_reg == sld_pkg::TYPE_BATTERY && length_reg >= 16'd1) begin
            result.frame_kind    = sld_pkg::KIND_BATTERY;
            result.battery_level = word_reg[31:24];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= sld_pkg::PH_HUNT;
            class_reg  <= '0;
            type_reg   <= '0;
            length_reg <= '0;
            left_reg   <= '0;
            word_reg   <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            class_reg  <= class_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            left_reg   <= left_next;
            word_reg   <= word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (accept && done) begin
            if (out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (accept && done) begin
            if (out_valid_reg && !pop) begin
                skid_data_reg <= result;
            end else begin
                out_data_reg <= result;
            end
        end
    end

endmodule

`default_nettype wire
